### sv/puh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Per-second usage history package
// Shared types, constants and saturation helpers for controller and datapath.
// ----------------------------------------------------------------------------
package puh_pkg;

	localparam int unsigned US_PER_SEC = 1000000;
	localparam logic [31:0] TPS_RESET  = 32'd1000000;

	localparam logic signed [63:0] S48_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] S48_MIN  = -64'sh0000_8000_0000_0000;
	localparam logic signed [63:0] S32_MAX  = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] S32_MIN  = -64'sh0000_0000_8000_0000;
	localparam logic signed [63:0] S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;

	// saturation limit of a scaling operation
	typedef enum logic [1:0] {
		LIM_S24,
		LIM_S48,
		LIM_WIDE
	} lim_t;

	// which scaling the datapath feeds to the shared mul/div unit
	typedef enum logic [2:0] {
		SC_GAP,
		SC_SHARE,
		SC_WIN,
		SC_LAST,
		SC_OLD
	} sc_op_t;

	typedef struct packed {
		logic   take;
		logic   eval;
		logic   sc_start;
		sc_op_t sc_op;
		logic   gap_done;
		logic   fill_step;
		logic   spr_part;
		logic   spr_close;
		logic   walk_init;
		logic   walk_step;
		logic   res_win;
		logic   res_last;
		logic   res_old;
		logic   load;
	} puh_cmd_t;

	typedef struct packed {
		logic rearm;
		logic gap;
		logic dt_zero;
		logic fits;
		logic idx_last;
		logic sc_done;
		logic out_free;
	} puh_sts_t;

	function automatic logic [63:0] lim_value(input lim_t l);
		logic [63:0] v;
		unique case (l)
			LIM_S24:  v = 64'h0000_0000_007F_FFFF;
			LIM_S48:  v = 64'h0000_7FFF_FFFF_FFFF;
			LIM_WIDE: v = 64'h3FFF_FFFF_FFFF_FFFF;
			default:  v = 64'h3FFF_FFFF_FFFF_FFFF;
		endcase
		return v;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		logic signed [47:0] r;
		if (v > S48_MAX) r = 48'sh7FFF_FFFF_FFFF;
		else if (v < S48_MIN) r = 48'sh8000_0000_0000;
		else r = v[47:0];
		return r;
	endfunction

	// divide by 256 toward zero, then clamp to 32 bits
	function automatic logic [31:0] div256_sat32(input logic signed [63:0] v);
		logic signed [63:0] q;
		logic [31:0] r;
		q = v[63] ? ((v + 64'sd255) >>> 8) : (v >>> 8);
		if (q > S32_MAX) r = 32'h7FFF_FFFF;
		else if (q < S32_MIN) r = 32'h8000_0000;
		else r = q[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/per_second_usage_history.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Per-second usage history
// Spreads busy-time deltas into one-second bins and reports window statistics.
// ----------------------------------------------------------------------------
// Usage: each input request carries a tick timestamp and a cumulative busy
// total in microseconds; every accepted request yields exactly one result
// request with the window fraction, last-second fraction and max/min bin.
// The input channel stalls from acceptance until the result is loaded into
// the output register, so one sample is in flight at a time. A waiting
// result does not block the next sample from being taken.
// Processing time is set by the shared scaling unit (4 multiply steps and 128
// divide steps per scaling), three scalings per sample and the walk over the
// bin ring, plus one more scaling for each second that closes, or one scaling
// and a pass over the ring when a long gap refills the ring.
// ticks_per_second is written via cfg_valid/cfg_ready/cfg_data; the user must
// only write it while idle, unchecked by the block; cfg_ready is always high.
// Reset clears the history (bins read as zero until written), arms the
// timestamp compare so the first sample only re-arms, and drops any result.
// When the receiver stalls, hold the result; the sample after it waits in
// its final step until the output register frees.
// ----------------------------------------------------------------------------
module per_second_usage_history import puh_pkg::*; #(
	parameter int HISTORY_DEPTH = 16,
	parameter int GAP_SECONDS   = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [63:0] timestamp,
	input  wire logic        [47:0] cumulative_us,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [23:0]      avg_window,
	output logic signed [23:0]      avg_last_second,
	output logic signed [31:0]      max_bin_us,
	output logic signed [31:0]      min_bin_us,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic        [31:0] cfg_data
);

	puh_cmd_t cmd;
	puh_sts_t sts;
	logic     cfg_we;

	// the user must write registers only while idle; unchecked, so take them all
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	puh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	puh_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.GAP_SECONDS   (GAP_SECONDS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.timestamp       (timestamp),
		.cumulative_us   (cumulative_us),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.avg_window      (avg_window),
		.avg_last_second (avg_last_second),
		.max_bin_us      (max_bin_us),
		.min_bin_us      (min_bin_us)
	);

	// an accepted sample closes the input until its result is loaded
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after a sample was taken");

	// a new result only appears at the end of a sample's processing
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a sample in flight");

	// the scaling unit only finishes while a sample is being processed
	a_scale_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.sc_done |-> in_stall)
		else $error("scaling finished while idle");

	// the output register is never loaded over a result still held
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid || !out_stall))
		else $error("result overwritten while stalled");

endmodule
`default_nettype wire

### sv/puh_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scaling unit
// Saturating a * m / d: 4-step 32x32 multiply, then 128-step restoring divide.
// ----------------------------------------------------------------------------
module puh_scale import puh_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] a,
	input  wire logic        [63:0] m,
	input  wire logic        [63:0] d,
	input  wire lim_t               lim,
	output logic                    done,
	output logic signed [63:0]      res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [6:0]         cnt_q;
	logic               done_q;
	logic signed [63:0] res_q;

	logic               neg_q;
	logic [63:0]        mag_q;
	logic [63:0]        m_q;
	logic [63:0]        d_q;
	lim_t               lim_q;
	logic [63:0]        pp_s1;
	logic               pp_vld_s1;
	logic [1:0]         pp_sel_s1;
	logic [127:0]       acc_q;
	logic [63:0]        rem_q;

	logic [31:0]        mag_half;
	logic [31:0]        m_half;
	logic [63:0]        pp;
	logic [6:0]         shamt;
	logic [127:0]       pp_ext;
	logic [64:0]        rem_sh;
	logic [64:0]        rem_sub;
	logic               ge;
	logic [63:0]        cap;
	logic [63:0]        q_mag;

	assign mag_half = cnt_q[1] ? mag_q[63:32] : mag_q[31:0];
	assign m_half   = cnt_q[0] ? m_q[63:32] : m_q[31:0];
	assign pp       = 64'(mag_half) * 64'(m_half);
	assign shamt    = {pp_sel_s1[1] & pp_sel_s1[0], pp_sel_s1[1] ^ pp_sel_s1[0], 5'b0};
	assign pp_ext   = {64'b0, pp_s1} << shamt;

	assign rem_sh  = {rem_q, acc_q[127]};
	assign ge      = rem_sh >= {1'b0, d_q};
	assign rem_sub = rem_sh - {1'b0, d_q};

	assign cap   = neg_q ? lim_value(lim_q) + 64'd1 : lim_value(lim_q);
	assign q_mag = ((|acc_q[127:64]) || (acc_q[63:0] > cap)) ? cap : acc_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					if (cnt_q == 7'd4) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_DIV: begin
					if (cnt_q == 7'd127) begin
						state_q <= ST_FIN;
					end
					cnt_q <= cnt_q + 7'd1;
				end
				ST_FIN: begin
					res_q   <= neg_q ? -$signed(q_mag) : $signed(q_mag);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			neg_q     <= a[63];
			mag_q     <= a[63] ? 64'(-a) : 64'(a);
			m_q       <= m;
			d_q       <= d;
			lim_q     <= lim;
			acc_q     <= '0;
			rem_q     <= '0;
			pp_vld_s1 <= 1'b0;
		end else if (state_q == ST_MUL) begin
			pp_s1     <= pp;
			pp_sel_s1 <= cnt_q[1:0];
			pp_vld_s1 <= cnt_q < 7'd4;
			if (pp_vld_s1) begin
				acc_q <= acc_q + pp_ext;
			end
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
			acc_q <= {acc_q[126:0], ge};
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

### sv/puh_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Usage history datapath
// Bin ring, accumulator, sample registers, walk logic and output register.
// ----------------------------------------------------------------------------
module puh_dp import puh_pkg::*; #(
	parameter int HISTORY_DEPTH = 16,
	parameter int GAP_SECONDS   = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire puh_cmd_t           cmd,
	output puh_sts_t                sts,
	input  wire logic               cfg_we,
	input  wire logic        [31:0] cfg_data,
	input  wire logic        [63:0] timestamp,
	input  wire logic        [47:0] cumulative_us,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output logic signed [23:0]      avg_window,
	output logic signed [23:0]      avg_last_second,
	output logic signed [31:0]      max_bin_us,
	output logic signed [31:0]      min_bin_us
);

	localparam int IW = $clog2(HISTORY_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);

	// architectural state
	logic [31:0]        tps_q;
	logic [63:0]        prev_time_q;
	logic [47:0]        prev_total_q;
	logic signed [47:0] partial_q;
	logic [31:0]        pt_q;
	logic [IW-1:0]      ns_q;
	logic [HISTORY_DEPTH-1:0] bin_vld_q;
	logic signed [47:0] bins_mem [HISTORY_DEPTH];

	// working registers
	logic [63:0]        in_ts_q;
	logic [47:0]        in_tot_q;
	logic [63:0]        dt_q;
	logic signed [63:0] du_q;
	logic signed [47:0] rate_q;
	logic [IW-1:0]      idx_q;
	logic signed [47:0] rdata_s1;
	logic               bvld_s1;
	logic               rd_vld_s1;
	logic [IW-1:0]      rd_idx_s1;
	logic signed [63:0] sum_q;
	logic signed [63:0] mx_q;
	logic signed [63:0] mn_q;
	logic signed [47:0] oldest_q;
	logic signed [47:0] newest_q;
	logic [23:0]        win_q;
	logic [23:0]        last_q;
	logic [31:0]        max_q;
	logic [31:0]        min_q;
	logic               out_valid_q;
	logic [23:0]        out_win_q;
	logic [23:0]        out_last_q;
	logic [31:0]        out_max_q;
	logic [31:0]        out_min_q;

	logic [31:0]        tpse;
	logic [63:0]        dt_new;
	logic signed [63:0] du_new;
	logic [63:0]        gap_lim;
	logic [31:0]        rest;
	logic [IW-1:0]      ns_nxt;
	logic [IW-1:0]      newest_idx;
	logic signed [63:0] partial_ext;
	logic signed [63:0] rd_ext;
	logic signed [63:0] sc_a;
	logic [63:0]        sc_m;
	logic [63:0]        sc_d;
	lim_t               sc_lim;
	logic               sc_done;
	logic signed [63:0] sc_res;
	logic signed [63:0] mx_fin;
	logic signed [63:0] mn_fin;
	logic               mem_we;
	logic [IW-1:0]      mem_wa;
	logic signed [47:0] mem_wd;

	assign tpse        = (tps_q == 32'd0) ? 32'd1 : tps_q;
	assign dt_new      = in_ts_q - prev_time_q;
	assign du_new      = ($signed({16'b0, in_tot_q}) - $signed({16'b0, prev_total_q})) <<< 8;
	assign gap_lim     = {32'b0, tpse} * 64'(GAP_SECONDS);
	assign rest        = (pt_q < tpse) ? tpse - pt_q : 32'd0;
	assign ns_nxt      = (ns_q == LAST_IDX) ? '0 : ns_q + 1'b1;
	assign newest_idx  = (ns_q == '0) ? LAST_IDX : ns_q - 1'b1;
	assign partial_ext = {{16{partial_q[47]}}, partial_q};
	assign rd_ext      = bvld_s1 ? {{16{rdata_s1[47]}}, rdata_s1} : 64'sd0;

	assign sts.rearm    = in_ts_q < prev_time_q;
	assign sts.gap      = dt_new > gap_lim;
	assign sts.dt_zero  = dt_q == 64'd0;
	assign sts.fits     = ({1'b0, dt_q} + 65'(pt_q)) < 65'(tpse);
	assign sts.idx_last = idx_q == LAST_IDX;
	assign sts.sc_done  = sc_done;
	assign sts.out_free = !out_valid_q || !out_stall;

	// operand select for the shared scaling unit
	always_comb begin
		sc_a   = du_q;
		sc_m   = 64'(tpse);
		sc_d   = dt_q;
		sc_lim = LIM_S48;
		unique case (cmd.sc_op)
			SC_GAP: begin
				sc_a   = du_q;
				sc_m   = 64'(tpse);
				sc_d   = dt_q;
				sc_lim = LIM_S48;
			end
			SC_SHARE: begin
				sc_a   = du_q;
				sc_m   = 64'(rest);
				sc_d   = dt_q;
				sc_lim = LIM_WIDE;
			end
			SC_WIN: begin
				sc_a   = sum_q;
				sc_m   = {24'b0, tpse, 8'b0};
				sc_d   = ({32'b0, tpse} * 64'(HISTORY_DEPTH) + 64'(pt_q)) * 64'(US_PER_SEC);
				sc_lim = LIM_S24;
			end
			SC_LAST: begin
				sc_a   = {{16{newest_q[47]}}, newest_q};
				sc_m   = {24'b0, rest, 8'b0};
				sc_d   = {32'b0, tpse} * 64'(US_PER_SEC);
				sc_lim = LIM_S24;
			end
			SC_OLD: begin
				sc_a   = {{16{oldest_q[47]}}, oldest_q};
				sc_m   = 64'(rest);
				sc_d   = 64'(tpse);
				sc_lim = LIM_WIDE;
			end
			default: begin
				sc_a   = du_q;
				sc_m   = 64'(tpse);
				sc_d   = dt_q;
				sc_lim = LIM_S48;
			end
		endcase
	end

	puh_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sc_start),
		.a      (sc_a),
		.m      (sc_m),
		.d      (sc_d),
		.lim    (sc_lim),
		.done   (sc_done),
		.res    (sc_res)
	);

	assign mem_we = cmd.fill_step || cmd.spr_close;
	assign mem_wa = cmd.fill_step ? idx_q : ns_q;
	assign mem_wd = cmd.fill_step ? rate_q : sat48(partial_ext + sc_res);

	assign mx_fin = (sc_res > mx_q) ? sc_res : mx_q;
	assign mn_fin = (sc_res < mn_q) ? sc_res : mn_q;

	// bin ring: unreset storage, valid bits stand in for the cleared history
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bins_mem[mem_wa] <= mem_wd;
		end
		rdata_s1 <= bins_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q        <= TPS_RESET;
			prev_time_q  <= '1;
			prev_total_q <= '0;
			partial_q    <= '0;
			pt_q         <= '0;
			ns_q         <= '0;
			bin_vld_q    <= '0;
			out_valid_q  <= 1'b0;
			rd_vld_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				tps_q <= cfg_data;
			end
			if (mem_we) begin
				bin_vld_q[mem_wa] <= 1'b1;
			end
			rd_vld_s1 <= cmd.walk_step;
			if (cmd.eval) begin
				prev_time_q  <= in_ts_q;
				prev_total_q <= in_tot_q;
				if (sts.rearm) begin
					partial_q <= '0;
					pt_q      <= '0;
				end
			end
			if (cmd.gap_done) begin
				partial_q <= '0;
				pt_q      <= '0;
			end
			if (cmd.spr_part) begin
				pt_q      <= pt_q + dt_q[31:0];
				partial_q <= sat48(partial_ext + du_q);
			end
			if (cmd.spr_close) begin
				partial_q <= '0;
				pt_q      <= '0;
				ns_q      <= ns_nxt;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			in_ts_q  <= timestamp;
			in_tot_q <= cumulative_us;
		end
		if (cmd.eval) begin
			dt_q <= dt_new;
			du_q <= du_new;
		end
		if (cmd.gap_done) begin
			rate_q <= sc_res[47:0];
			idx_q  <= '0;
		end
		if (cmd.fill_step) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.spr_close) begin
			dt_q <= dt_q - 64'(rest);
			du_q <= du_q - sc_res;
		end
		if (cmd.walk_init) begin
			idx_q <= '0;
			sum_q <= partial_ext;
			mx_q  <= S64_MIN;
			mn_q  <= S64_MAX;
		end
		if (cmd.walk_step) begin
			idx_q     <= idx_q + 1'b1;
			bvld_s1   <= bin_vld_q[idx_q];
			rd_idx_s1 <= idx_q;
		end
		// fold in the bin read last cycle; the oldest bin is scaled later
		if (rd_vld_s1) begin
			sum_q <= sum_q + rd_ext;
			if (rd_idx_s1 == ns_q) begin
				oldest_q <= rd_ext[47:0];
			end else begin
				if (rd_ext > mx_q) mx_q <= rd_ext;
				if (rd_ext < mn_q) mn_q <= rd_ext;
			end
			if (rd_idx_s1 == newest_idx) begin
				newest_q <= rd_ext[47:0];
			end
		end
		if (cmd.res_win) begin
			win_q <= sc_res[23:0];
		end
		if (cmd.res_last) begin
			last_q <= sc_res[23:0];
		end
		if (cmd.res_old) begin
			max_q <= div256_sat32(mx_fin);
			min_q <= div256_sat32(mn_fin);
		end
		if (cmd.load) begin
			out_win_q  <= win_q;
			out_last_q <= last_q;
			out_max_q  <= max_q;
			out_min_q  <= min_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign avg_window      = out_win_q;
	assign avg_last_second = out_last_q;
	assign max_bin_us      = out_max_q;
	assign min_bin_us      = out_min_q;

endmodule
`default_nettype wire

### sv/puh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Usage history controller
// Sequences one sample: update, spread or fill, walk the ring, three scalings.
// ----------------------------------------------------------------------------
module puh_ctrl import puh_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output puh_cmd_t      cmd,
	input  wire puh_sts_t sts
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_EVAL,
		ST_GAP_GO,
		ST_GAP_WAIT,
		ST_FILL,
		ST_SPR_CHK,
		ST_SPR_WAIT,
		ST_WALK_INIT,
		ST_WALK,
		ST_WALK_END,
		ST_WIN_GO,
		ST_WIN_WAIT,
		ST_LAST_GO,
		ST_LAST_WAIT,
		ST_OLD_GO,
		ST_OLD_WAIT,
		ST_LOAD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   busy_d;

	always_comb begin
		state_d  = state_q;
		busy_d   = busy_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !busy_q) begin
					cmd.take = 1'b1;
					busy_d   = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.rearm) state_d = ST_WALK_INIT;
				else if (sts.gap) state_d = ST_GAP_GO;
				else state_d = ST_SPR_CHK;
			end
			ST_GAP_GO: begin
				cmd.sc_start = 1'b1;
				cmd.sc_op    = SC_GAP;
				state_d      = ST_GAP_WAIT;
			end
			ST_GAP_WAIT: begin
				if (sts.sc_done) begin
					cmd.gap_done = 1'b1;
					state_d      = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.idx_last) state_d = ST_WALK_INIT;
			end
			ST_SPR_CHK: begin
				if (sts.dt_zero) begin
					state_d = ST_WALK_INIT;
				end else if (sts.fits) begin
					cmd.spr_part = 1'b1;
					state_d      = ST_WALK_INIT;
				end else begin
					cmd.sc_start = 1'b1;
					cmd.sc_op    = SC_SHARE;
					state_d      = ST_SPR_WAIT;
				end
			end
			ST_SPR_WAIT: begin
				cmd.sc_op = SC_SHARE;
				if (sts.sc_done) begin
					cmd.spr_close = 1'b1;
					state_d       = ST_SPR_CHK;
				end
			end
			ST_WALK_INIT: begin
				cmd.walk_init = 1'b1;
				state_d       = ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.idx_last) state_d = ST_WALK_END;
			end
			ST_WALK_END: begin
				state_d = ST_WIN_GO;
			end
			ST_WIN_GO: begin
				cmd.sc_start = 1'b1;
				cmd.sc_op    = SC_WIN;
				state_d      = ST_WIN_WAIT;
			end
			ST_WIN_WAIT: begin
				if (sts.sc_done) begin
					cmd.res_win = 1'b1;
					state_d     = ST_LAST_GO;
				end
			end
			ST_LAST_GO: begin
				cmd.sc_start = 1'b1;
				cmd.sc_op    = SC_LAST;
				state_d      = ST_LAST_WAIT;
			end
			ST_LAST_WAIT: begin
				if (sts.sc_done) begin
					cmd.res_last = 1'b1;
					state_d      = ST_OLD_GO;
				end
			end
			ST_OLD_GO: begin
				cmd.sc_start = 1'b1;
				cmd.sc_op    = SC_OLD;
				state_d      = ST_OLD_WAIT;
			end
			ST_OLD_WAIT: begin
				if (sts.sc_done) begin
					cmd.res_old = 1'b1;
					state_d     = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					busy_d   = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= busy_d;
		end
	end

	assign in_stall = busy_q;

endmodule
`default_nettype wire
